[src/irpwd_pkg.sv]
// irpwd_pkg: shared types, constants and register codes for the IR pulse width decoder.
// No dependencies; used by every other file of the block.
package irpwd_pkg;

  localparam int SLOTS    = 64;
  localparam int SLOT_W   = $clog2(SLOTS + 1);
  localparam int IVL_W    = 8;
  localparam int CODE_W   = 16;
  localparam int COUNT_W  = 16;
  localparam int SKIP_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [IVL_W-1:0] ONE_THRESHOLD_RESET = IVL_W'(30);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_THRESHOLD = 2'd0,
    CFG_SKIP_COUNT      = 2'd1,
    CFG_ONE_THRESHOLD   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [IVL_W-1:0]  start_threshold;
    logic [SKIP_W-1:0] skip_count;
    logic [IVL_W-1:0]  one_threshold;
  } cfg_t;

  typedef struct packed {
    logic              capturing;
    logic [SLOT_W-1:0] slot_index;
    logic [SLOT_W-1:0] first_data_slot;
    logic [CODE_W-1:0] code_accum;
    logic              stopped;
  } frame_t;

  localparam frame_t FRAME_IDLE = '{
    capturing:       1'b0,
    slot_index:      '0,
    first_data_slot: '0,
    code_accum:      '0,
    stopped:         1'b0
  };

endpackage

[src/irpwd_if.sv]
// irpwd_ev_if / irpwd_res_if: valid/ready channels for detector events and decoded codes.
// Depends on irpwd_pkg for field widths.
interface irpwd_ev_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [irpwd_pkg::IVL_W-1:0] interval;

  modport source (output valid, output opcode, output interval, input ready);
  modport sink   (input valid, input opcode, input interval, output ready);
endinterface

interface irpwd_res_if;
  logic                          valid;
  logic                          ready;
  logic [irpwd_pkg::CODE_W-1:0]  code;
  logic [irpwd_pkg::COUNT_W-1:0] code_count;

  modport source (output valid, output code, output code_count, input ready);
  modport sink   (input valid, input code, input code_count, output ready);
endinterface

[src/irpwd_frame.sv]
// irpwd_frame: next-state logic of the frame decoder for one event item.
// Depends on irpwd_pkg (frame_t, cfg_t, widths).
module irpwd_frame (
  input  irpwd_pkg::frame_t                st,
  input  irpwd_pkg::cfg_t                  cfg,
  input  logic                             opcode,
  input  logic [irpwd_pkg::IVL_W-1:0]      interval,
  output irpwd_pkg::frame_t                st_next,
  output logic                             emit,
  output logic [irpwd_pkg::CODE_W-1:0]     emit_code
);

  localparam logic [irpwd_pkg::SLOT_W-1:0] LastSlot = irpwd_pkg::SLOT_W'(irpwd_pkg::SLOTS - 1);

  logic                            start_hit;
  logic [irpwd_pkg::SLOT_W-1:0]    first_slot;
  logic [irpwd_pkg::CODE_W-1:0]    code_bit;
  logic [irpwd_pkg::CODE_W-1:0]    code_new;
  logic                            stop_new;
  logic                            collect;
  logic                            last;

  always_comb begin
    start_hit  = (cfg.start_threshold != '0) && (interval >= cfg.start_threshold);
    first_slot = (st.slot_index == '0)
               ? irpwd_pkg::SLOT_W'({1'b0, cfg.skip_count}) + irpwd_pkg::SLOT_W'(start_hit)
               : st.first_data_slot;
    last       = (st.slot_index == LastSlot);
    collect    = (st.slot_index >= first_slot) && !st.stopped;
    code_bit   = st.code_accum | irpwd_pkg::CODE_W'(interval >= cfg.one_threshold);
    code_new   = st.code_accum;
    stop_new   = st.stopped;
    if (collect) begin
      if (interval == '0) begin
        stop_new = 1'b1;
      end else if (last) begin
        code_new = code_bit;
      end else begin
        code_new = {code_bit[irpwd_pkg::CODE_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    st_next   = st;
    emit      = 1'b0;
    emit_code = st.code_accum;
    if (opcode) begin
      if (st.capturing) begin
        emit    = (st.code_accum != '0);
        st_next = irpwd_pkg::FRAME_IDLE;
      end
    end else if (!st.capturing) begin
      st_next           = irpwd_pkg::FRAME_IDLE;
      st_next.capturing = 1'b1;
    end else if (last) begin
      emit      = (code_new != '0);
      emit_code = code_new;
      st_next   = irpwd_pkg::FRAME_IDLE;
    end else begin
      st_next.slot_index      = st.slot_index + 1'b1;
      st_next.first_data_slot = first_slot;
      st_next.code_accum      = code_new;
      st_next.stopped         = stop_new;
    end
  end

endmodule

[src/ir_pulse_width_decoder.sv]
// ir_pulse_width_decoder: top level of the IR remote pulse width decoder.
// Depends on irpwd_pkg, irpwd_if (channels) and irpwd_frame (per-item update).
//
//   channel  dir  handshake     payload
//   ev       in   valid/ready   opcode, interval
//   res      out  valid/ready   code, code_count
//   cfg      in   cfg_we        cfg_index, cfg_data
//
// One event item per cycle while ev.ready is high; its result is in the output register the next cycle.
// The frame update is combinational and feeds a one-deep output register.
// ev.ready drops only while a result waits in the output register and res.ready is low.
// rst is synchronous, active high; clears frame state and code count, resets config.
module ir_pulse_width_decoder (
  input  logic                                clk,
  input  logic                                rst,
  irpwd_ev_if.sink                            ev,
  irpwd_res_if.source                         res,
  input  logic                                cfg_we,
  input  logic [irpwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irpwd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  irpwd_pkg::cfg_t                   cfg;
  irpwd_pkg::frame_t                 st;
  irpwd_pkg::frame_t                 st_next;
  logic [irpwd_pkg::COUNT_W-1:0]     total;
  logic [irpwd_pkg::COUNT_W-1:0]     total_next;
  logic                              emit;
  logic [irpwd_pkg::CODE_W-1:0]      emit_code;
  logic                              out_valid;
  logic [irpwd_pkg::CODE_W-1:0]      out_code;
  logic [irpwd_pkg::COUNT_W-1:0]     out_count;
  logic                              accept;

  irpwd_frame u_frame (
    .st        (st),
    .cfg       (cfg),
    .opcode    (ev.opcode),
    .interval  (ev.interval),
    .st_next   (st_next),
    .emit      (emit),
    .emit_code (emit_code)
  );

  assign ev.ready   = !out_valid || res.ready;
  assign accept     = ev.valid && ev.ready;
  assign total_next = total + 1'b1;

  assign res.valid      = out_valid;
  assign res.code       = out_code;
  assign res.code_count = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_threshold <= '0;
      cfg.skip_count      <= '0;
      cfg.one_threshold   <= irpwd_pkg::ONE_THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (irpwd_pkg::cfg_idx_t'(cfg_index))
        irpwd_pkg::CFG_START_THRESHOLD: cfg.start_threshold <= cfg_data;
        irpwd_pkg::CFG_SKIP_COUNT:      cfg.skip_count      <= cfg_data[irpwd_pkg::SKIP_W-1:0];
        irpwd_pkg::CFG_ONE_THRESHOLD:   cfg.one_threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= irpwd_pkg::FRAME_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      if (accept && emit) begin
        total     <= total_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_code  <= emit_code;
      out_count <= total_next;
    end
  end

endmodule

[src/irpwd_checker.sv]
// irpwd_checker: port-level assertions for ir_pulse_width_decoder, attached by bind.
// Depends on irpwd_pkg for widths.
module irpwd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              ev_valid,
  input logic                              ev_ready,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic [irpwd_pkg::CODE_W-1:0]      res_code,
  input logic [irpwd_pkg::COUNT_W-1:0]     res_code_count
);

  // a waiting result holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_code) && $stable(res_code_count))
    else $error("result item changed while stalled");

  a_code_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_code != '0)
    else $error("zero code emitted");

  // a full, stalled output register must block new events
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !ev_ready)
    else $error("event accepted while result stalled");

  // a fresh result only follows an accepted event
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(ev_valid && ev_ready))
    else $error("result without an accepted event");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind ir_pulse_width_decoder irpwd_checker u_irpwd_checker (
  .clk            (clk),
  .rst            (rst),
  .ev_valid       (ev.valid),
  .ev_ready       (ev.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_code       (res.code),
  .res_code_count (res.code_count)
);
